/* hdl/sha1_pkg.sv */
// SHA-1 digest package: shared constants, control struct and round functions.
// No dependencies.
`timescale 1ns / 1ps
package sha1_pkg;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW = 2;
    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20) return 32'h5A827999;
        else if (r < 7'd40) return 32'h6ED9EBA1;
        else if (r < 7'd60) return 32'h8F1BBCDC;
        else return 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20) return (b & c) | (~b & d);
        else if (r < 7'd40) return b ^ c ^ d;
        else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
        else return b ^ c ^ d;
    endfunction
endpackage

/* hdl/sha1_front.sv */
// SHA-1 front end: input queue that buffers incoming beats.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha1_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output sha1_pkg::t_item o_item,
    input  logic           i_take
);
    import sha1_pkg::*;
    t_item r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0] r_cnt;
    logic w_wr, w_rd;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_wr = i_push && !o_full;
    assign w_rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_wr) - (QAW+1)'(w_rd);
        end
    end
endmodule

/* hdl/sha1_back.sv */
// SHA-1 back end: block assembly, padding, 80-round compression, digest output.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sha1_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    import sha1_pkg::*;
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_RND  = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_st, n_st;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [60:0] r_cnt;
    logic [5:0]  r_pos;
    logic [6:0]  r_rnd;
    logic        r_fin, r_lenblk;
    logic [2:0]  r_oi;
    logic [31:0] w_t, w_wn;
    logic [63:0] w_bits;
    logic        w_wbyte;
    logic [7:0]  w_byte;
    logic [5:0]  w_bpos;
    logic [60:0] w_cnt1;

    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_empty = (r_st != S_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd4);

    assign w_t  = {r_a[26:0], r_a[31:27]} + round_f(r_rnd, r_b, r_c, r_d) + r_e
                  + round_k(r_rnd) + r_w[0];
    assign w_wn = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_bits = {r_cnt, 3'b000};
    assign w_cnt1 = r_cnt + 61'd1;

    always_comb begin
        w_wbyte = 1'b0;
        w_byte  = i_item.msg_byte;
        w_bpos  = r_cnt[5:0];
        if (r_st == S_IDLE && i_valid && i_item.has_byte) begin
            w_wbyte = 1'b1;
        end else if (r_st == S_PAD) begin
            w_wbyte = 1'b1;
            w_bpos  = r_pos;
            w_byte  = (r_pos == r_cnt[5:0]) ? PAD_BYTE : 8'h00;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) begin
                if (i_item.has_byte && r_cnt[5:0] == 6'd63) n_st = S_RND;
                else if (i_item.end_of_message) n_st = S_PAD;
            end
            S_PAD: if (r_pos == 6'd63 || r_pos == 6'd55 && r_lenblk) n_st = S_RND;
            S_RND: if (r_rnd == 7'd79) n_st = S_ADD;
            S_ADD: n_st = r_fin ? (r_lenblk ? S_OUT : S_PAD) : S_IDLE;
            S_OUT: if (i_pop && r_oi == 3'd4) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wbyte) begin
            case (w_bpos[1:0])
                2'd0: r_w[w_bpos[5:2]][31:24] <= w_byte;
                2'd1: r_w[w_bpos[5:2]][23:16] <= w_byte;
                2'd2: r_w[w_bpos[5:2]][15:8]  <= w_byte;
                default: r_w[w_bpos[5:2]][7:0] <= w_byte;
            endcase
        end
        if (r_st == S_PAD && r_lenblk && r_pos == 6'd55) begin
            r_w[14] <= w_bits[63:32];
            r_w[15] <= w_bits[31:0];
        end
        if (r_st == S_RND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= {w_wn[30:0], w_wn[31]};
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            for (int i = 0; i < 5; i++) r_h[i] <= H_INIT[i];
            r_cnt <= '0;
            r_pos <= '0;
            r_rnd <= '0;
            r_fin <= 1'b0;
            r_lenblk <= 1'b0;
            r_oi <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_fin <= i_item.end_of_message;
                    r_rnd <= '0;
                    if (i_item.has_byte) begin
                        r_cnt <= w_cnt1;
                        r_pos <= w_cnt1[5:0];
                        r_lenblk <= (w_cnt1[5:0] < 6'd56) && (w_cnt1[5:0] != 6'd0);
                    end else begin
                        r_pos <= r_cnt[5:0];
                        r_lenblk <= (r_cnt[5:0] < 6'd56);
                    end
                end
                S_PAD: r_pos <= r_pos + 6'd1;
                S_RND: r_rnd <= r_rnd + 7'd1;
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_rnd <= '0;
                    r_oi <= '0;
                    r_lenblk <= 1'b1;
                    if (r_fin && !r_lenblk) r_pos <= '0;
                end
                S_OUT: if (i_pop) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd4) begin
                        for (int i = 0; i < 5; i++) r_h[i] <= H_INIT[i];
                        r_cnt <= '0;
                        r_fin <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* hdl/sha1_message_digest.sv */
// Channel   | handshake     | payload
// input     | i_push/o_full | i_msg_byte, i_has_byte, i_end_of_message
// result    | o_empty/i_pop | o_digest_word, o_word_index, o_last_word
// A byte beat is taken in the back end's idle state; the 64th byte of a block adds
// a compression (one round per cycle, then the chaining add).
// An end beat adds padding (one byte per cycle) and one or two compressions.
// A four-beat input queue absorbs beats while the back end is busy.
// Reset is synchronous, active low; the result side holds while i_pop is low.
`timescale 1ns / 1ps
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1_pkg::*;
    t_item w_in, w_q;
    logic w_valid, w_take;

    assign w_in = '{msg_byte: i_msg_byte, has_byte: i_has_byte,
                    end_of_message: i_end_of_message};

    sha1_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(w_in),
        .o_full(o_full), .o_valid(w_valid), .o_item(w_q), .i_take(w_take)
    );

    sha1_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_q),
        .o_take(w_take), .o_empty(o_empty), .i_pop(i_pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );
endmodule

/* hdl/sha1_checker.sv */
// Port-level checker for sha1_message_digest, attached by bind.
// No dependencies.
`timescale 1ns / 1ps
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic [31:0] o_digest_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_word == (o_word_index == 3'd4)))
        else $error("last_word mismatch");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_word_index <= 3'd4))
        else $error("word_index out of range");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_word) |=> (!o_empty &&
        o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not consecutive");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_digest_word)))
        else $error("result changed while stalled");
endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop),
    .o_word_index(o_word_index), .o_last_word(o_last_word),
    .o_digest_word(o_digest_word)
);

/* verif/sha1_message_digest_test.sv */
// Self-checking bench for sha1_message_digest: byte beats in, five digest words out.
// Drives messages through the push/full queue and compares each popped word with a
// behavioral SHA-1 kept in this file. Depends on hdl/sha1_pkg.sv and the block.
`timescale 1ns / 1ps
module sha1_message_digest_test;
    import sha1_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [7:0]  i_msg_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty, o_last_word;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;

    sha1_message_digest dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [31:0] hash_words [5];
    logic [31:0] msg_block [16];
    logic [60:0] msg_len;
    t_item       beat_queue [$];
    t_digest     digest_queue [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          stim_done = 0;
    logic        push_acc = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) w[r] = msg_block[r];
        for (int r = 16; r < 80; r++) w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
        d = hash_words[3]; e = hash_words[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
        hash_words[3] += d; hash_words[4] += e;
    endtask

    task automatic store_byte(input int pos, input logic [7:0] v);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    endtask

    task automatic queue_beat(input t_item it);
        beat_queue.insert(beat_queue.size(), it);
    endtask

    task automatic hash_beat(input t_item it);
        int pos;
        logic [63:0] bits;
        t_digest dg;
        if (it.has_byte) begin
            store_byte(int'(msg_len[5:0]), it.msg_byte);
            msg_len = msg_len + 1;
            if (msg_len[5:0] == 0) compress();
        end
        if (it.end_of_message) begin
            pos = int'(msg_len[5:0]);
            store_byte(pos, PAD_BYTE);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    store_byte(pos, 8'h00);
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                store_byte(pos, 8'h00);
                pos++;
            end
            bits = {msg_len, 3'b000};
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            compress();
            for (int i = 0; i < 5; i++) begin
                dg.word = hash_words[i];
                dg.index = 3'(i);
                dg.last = (i == 4);
                digest_queue.insert(digest_queue.size(), dg);
            end
            hash_words = H_INIT;
            msg_len = '0;
        end
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_item mk(input logic [7:0] v, input logic h, input logic e);
        t_item it;
        it.msg_byte = v; it.has_byte = h; it.end_of_message = e;
        return it;
    endfunction

    task automatic add_message(input int len);
        for (int i = 0; i < len; i++) queue_beat(mk(8'($urandom), 1'b1, 1'b0));
    endtask

    // input beat accepted at this rising edge
    always @(posedge i_clk) begin
        push_acc <= i_rst_n && i_push && !o_full;
    end

    // driver
    int push_gap = 0;
    int pop_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (push_acc) begin
                hash_beat(beat_queue.pop_front());
                push_gap = gap_len();
            end
            if (!i_push || push_acc) begin
                if (push_gap > 0) begin
                    push_gap--;
                    i_push <= 1'b0;
                end else if (beat_queue.size() > 0) begin
                    i_push <= 1'b1;
                    {i_msg_byte, i_has_byte, i_end_of_message} <= beat_queue[0];
                end else begin
                    i_push <= 1'b0;
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                i_pop <= 1'b0;
            end else begin
                pop_gap = gap_len();
                i_pop <= 1'b1;
            end
        end
    end

    // monitor
    t_digest want;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_pop && !o_empty) begin
            if (digest_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h idx %0d", o_digest_word,
                                               o_word_index);
            end else begin
                want = digest_queue.pop_front();
                if (o_digest_word !== want.word || o_word_index !== want.index ||
                    o_last_word !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", want.word,
                                 want.index, want.last, o_digest_word, o_word_index,
                                 o_last_word);
                end
            end
        end
    end

    initial begin
        int roll, len;
        hash_words = H_INIT;
        msg_block = '{default: '0};
        msg_len = '0;
        // directed: empty, one byte extremes, idle beats, pad boundaries
        queue_beat(mk(8'hFF, 1'b0, 1'b1));
        queue_beat(mk(8'h00, 1'b1, 1'b1));
        queue_beat(mk(8'hA5, 1'b0, 1'b0));
        queue_beat(mk(8'hFF, 1'b1, 1'b1));
        queue_beat(mk(8'h5A, 1'b1, 1'b0));
        queue_beat(mk(8'h3C, 1'b0, 1'b1));
        add_message(55); queue_beat(mk(8'h00, 1'b0, 1'b1));
        add_message(63); queue_beat(mk(8'h81, 1'b1, 1'b1));
        // random messages, mostly short, a few spanning blocks
        for (int n = beat_queue.size(); n < 210;) begin
            roll = $urandom_range(0, 9);
            len = (roll < 7) ? $urandom_range(0, 12) : $urandom_range(13, 130);
            if (len > 210 - n) len = 210 - n;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_beat(mk(8'($urandom), 1'b0, 1'b0));
                queue_beat(mk(8'($urandom), 1'b1, 1'b0));
            end
            if (len > 0 && $urandom_range(0, 1))
                beat_queue[$].end_of_message = 1'b1;
            else
                queue_beat(mk(8'($urandom), 1'b0, 1'b1));
            n += len + 1;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (beat_queue.size() == 0 && !i_push && digest_queue.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        wait (cycle_count == 2000000);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
